@@ hw/rtl/format_conversion_char_emitter_core_macros.svh @@
// assertion shorthands used by the checker file
`ifndef FORMAT_CONVERSION_CHAR_EMITTER_CORE_MACROS_SVH
`define FORMAT_CONVERSION_CHAR_EMITTER_CORE_MACROS_SVH

// consequent must hold in the same cycle
`define FCCE_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcce check failed");

// consequent must hold in the following cycle
`define FCCE_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcce check failed");

`endif

@@ hw/rtl/fcce_pkg.sv @@
package fcce_pkg;

	typedef struct packed {
		logic [7:0]  fmt_char;
		logic [31:0] arg_word;
	} fmt_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} chr_item_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_DEC  = 4'b0100,
		ST_HEX  = 4'b1000
	} state_t;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_C       = 8'h63;
	localparam logic [7:0] CH_D       = 8'h64;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	// reciprocal of ten, scaled by 2^35
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// glyph for one digit, 0-9 then A-F
	function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
		logic [7:0] g;
		if (nib < 4'd10) begin
			g = CH_ZERO + {4'd0, nib};
		end else begin
			g = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return g;
	endfunction

endpackage

@@ hw/rtl/fcce_div10.sv @@
module fcce_div10
	import fcce_pkg::*;
(
	input  logic [31:0] mag,
	output logic [31:0] quo,
	output logic [3:0]  rem
);

	logic [63:0] prod;
	logic [31:0] quo_x10;
	logic [31:0] diff;

	// floor(mag / 10) is exact for every 32-bit value with this reciprocal
	assign prod    = {32'd0, mag} * {32'd0, RECIP_TEN};
	assign quo     = {3'd0, prod[63:RECIP_SHIFT]};
	assign quo_x10 = {quo[28:0], 3'd0} + {quo[30:0], 1'b0};
	assign diff    = mag - quo_x10;
	assign rem     = diff[3:0];

endmodule

@@ hw/rtl/fcce_digit_store.sv @@
module fcce_digit_store #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// a read of the address being written returns the new data
		if (wr_en && wr_addr == rd_addr) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/format_conversion_char_emitter_core.sv @@
// Formats a stream of format characters into output characters (%c, %d, %x).
// Input channel fmt_valid/fmt_stall/fmt_item carries one format character and
// a 32-bit argument word; output channel chr_valid/chr_stall/chr_item carries
// one character, with last set on the final character an item produces.
// An ordinary character or %c appears on the output the cycle after accept.
// %x emits HEX_DIGITS characters via ST_HEX, one a cycle unless the output stalls.
// %d first emits the minus sign if needed, then runs one divide-by-ten step
// per cycle on the single reciprocal multiplier (at most MAX_DEC_DIGITS steps),
// then emits the digits most significant first, one a cycle unless the output
// stalls. '%' itself and unknown conversions emit nothing.
// The input is stalled while a conversion is being produced and while the
// output register holds a character that the receiver is stalling; a stall on
// the output pauses the emitting states with nothing lost.
// Reset clears the pending-percent flag, the sequencer and the output valid.
module format_conversion_char_emitter_core
	import fcce_pkg::*;
#(
	parameter int HEX_DIGITS     = 8,
	parameter int MAX_DEC_DIGITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fmt_valid,
	output logic      fmt_stall,
	input  fmt_item_t fmt_item,
	output logic      chr_valid,
	input  logic      chr_stall,
	output chr_item_t chr_item
);

	localparam int HW  = HEX_DIGITS * 4;
	localparam int HCW = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;
	localparam int DIW = (MAX_DEC_DIGITS > 1) ? $clog2(MAX_DEC_DIGITS) : 1;
	localparam logic [DIW-1:0] IdxLast = DIW'(MAX_DEC_DIGITS - 1);
	localparam logic [HCW-1:0] HexLast = HCW'(HEX_DIGITS - 1);

	state_t          state_q, state_d;
	logic            pending_q, pending_d;
	logic            chr_valid_q;
	chr_item_t       chr_item_q;
	logic [31:0]     mag_q;
	logic [HW-1:0]   hex_q;
	logic [HCW-1:0]  hexcnt_q;
	logic [DIW-1:0]  idx_q;

	logic            accept;
	logic            out_free;
	logic            emit_en;
	chr_item_t       emit_item;
	logic            load_dec;
	logic            load_hex;
	logic            step_hex;
	logic            div_en;
	logic            dec_step;
	logic [31:0]     quo;
	logic [3:0]      rem;
	logic [3:0]      rd_digit;
	logic [DIW-1:0]  rd_idx;
	logic [31:0]     neg_mag;

	fcce_div10 u_div (
		.mag (mag_q),
		.quo (quo),
		.rem (rem)
	);

	fcce_digit_store #(
		.WIDTH (4),
		.DEPTH (MAX_DEC_DIGITS),
		.AW    (DIW)
	) u_store (
		.clk     (clk),
		.wr_en   (div_en),
		.wr_addr (idx_q),
		.wr_data (rem),
		.rd_addr (rd_idx),
		.rd_data (rd_digit)
	);

	assign out_free  = !chr_valid_q || !chr_stall;
	assign fmt_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = fmt_valid && !fmt_stall;
	assign neg_mag   = 32'd0 - fmt_item.arg_word;
	// fetch the digit that idx_q will point at after this edge
	assign rd_idx    = (dec_step && idx_q != '0) ? idx_q - 1'b1 : idx_q;

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		emit_en   = 1'b0;
		emit_item = '{out_char: fmt_item.fmt_char, last: 1'b1};
		load_dec  = 1'b0;
		load_hex  = 1'b0;
		step_hex  = 1'b0;
		div_en    = 1'b0;
		dec_step  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!pending_q) begin
						if (fmt_item.fmt_char == CH_PERCENT) begin
							pending_d = 1'b1;
						end else begin
							emit_en = 1'b1;
						end
					end else begin
						pending_d = 1'b0;
						case (fmt_item.fmt_char)
							CH_C: begin
								emit_en   = 1'b1;
								emit_item = '{out_char: fmt_item.arg_word[7:0], last: 1'b1};
							end
							CH_D: begin
								load_dec  = 1'b1;
								state_d   = ST_DIV;
								emit_en   = fmt_item.arg_word[31];
								emit_item = '{out_char: CH_MINUS, last: 1'b0};
							end
							CH_X: begin
								load_hex = 1'b1;
								state_d  = ST_HEX;
							end
							default: ;
						endcase
					end
				end
			end
			ST_DIV: begin
				div_en = 1'b1;
				if (quo == 32'd0 || idx_q == IdxLast) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				emit_item = '{out_char: hex_glyph(rd_digit), last: idx_q == '0};
				if (out_free) begin
					emit_en  = 1'b1;
					dec_step = 1'b1;
					if (idx_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_HEX: begin
				emit_item = '{out_char: hex_glyph(hex_q[HW-1 -: 4]), last: hexcnt_q == '0};
				if (out_free) begin
					emit_en  = 1'b1;
					step_hex = 1'b1;
					if (hexcnt_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pending_q   <= 1'b0;
			chr_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
			if (emit_en) begin
				chr_valid_q <= 1'b1;
			end else if (!chr_stall) begin
				chr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			chr_item_q <= emit_item;
		end
		if (load_dec) begin
			mag_q <= fmt_item.arg_word[31] ? neg_mag : fmt_item.arg_word;
			idx_q <= '0;
		end else if (div_en) begin
			mag_q <= quo;
			// on the final step idx_q stays on the most significant digit
			if (!(quo == 32'd0 || idx_q == IdxLast)) begin
				idx_q <= idx_q + 1'b1;
			end
		end else if (dec_step && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (load_hex) begin
			hex_q    <= HW'(fmt_item.arg_word);
			hexcnt_q <= HexLast;
		end else if (step_hex) begin
			hex_q    <= hex_q << 4;
			hexcnt_q <= hexcnt_q - 1'b1;
		end
	end

	assign chr_valid = chr_valid_q;
	assign chr_item  = chr_item_q;

endmodule

@@ hw/rtl/fcce_checker.sv @@
`include "format_conversion_char_emitter_core_macros.svh"

module fcce_checker
	import fcce_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      fmt_valid,
	input logic      fmt_stall,
	input fmt_item_t fmt_item,
	input logic      chr_valid,
	input logic      chr_stall,
	input chr_item_t chr_item
);

	// a stalled character stays put
	`FCCE_AST_NEXT(a_chr_hold, chr_valid && chr_stall, chr_valid && $stable(chr_item))

	// no new item while a character is held back by the receiver
	`FCCE_AST_NOW(a_no_accept_blocked, fmt_valid && !fmt_stall, !(chr_valid && chr_stall))

	// mid-conversion the input is closed
	`FCCE_AST_NOW(a_busy_mid_item, chr_valid && !chr_item.last, fmt_stall)

	// a character before the final one is a minus sign or a digit glyph
	`FCCE_AST_NOW(a_inner_char_glyph, chr_valid && !chr_item.last, (chr_item.out_char == CH_MINUS) || (chr_item.out_char >= CH_ZERO && chr_item.out_char <= CH_ZERO + 8'd9) || (chr_item.out_char >= CH_UPPER_A && chr_item.out_char <= CH_UPPER_A + 8'd5))

endmodule

bind format_conversion_char_emitter_core fcce_checker u_fcce_checker (.*);

@@ tb/format_conversion_char_emitter_core_tb.sv @@
`timescale 1ns / 1ps

module format_conversion_char_emitter_core_tb;
	import fcce_pkg::*;

	localparam int HEX_COUNT = 8;
	localparam int DEC_LIMIT = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 76;
	localparam logic [8*16-1:0] GLYPHS = "0123456789ABCDEF";

	// characters outside the conversion set, used on purpose
	localparam logic [7:0] CH_Q    = 8'h71;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_ALL1 = 8'hFF;
	localparam logic [7:0] CH_A    = 8'h41;

	// expected output text, built from each accepted format item
	class emitted_text_board;
		bit          percent_armed;
		chr_item_t   expected_chars[$];
		int          mismatches;
		int          checked;

		function void note_format(fmt_item_t it);
			logic [7:0]  text[$];
			logic [31:0] mag;
			logic [3:0]  digs[DEC_LIMIT];
			logic [63:0] wide;
			logic [3:0]  nib;
			int          nd;
			chr_item_t   c;
			if (!percent_armed) begin
				if (it.fmt_char == CH_PERCENT) begin
					percent_armed = 1'b1;
				end else begin
					text.push_back(it.fmt_char);
				end
			end else begin
				percent_armed = 1'b0;
				case (it.fmt_char)
					CH_C: begin
						text.push_back(it.arg_word[7:0]);
					end
					CH_D: begin
						mag = it.arg_word;
						if (mag[31]) begin
							text.push_back(CH_MINUS);
							// magnitude as unsigned, so the most negative value works
							mag = 32'd0 - mag;
						end
						nd = 0;
						do begin
							digs[nd] = 4'(mag % 32'd10);
							nd++;
							mag = mag / 32'd10;
						end while (mag != 32'd0 && nd < DEC_LIMIT);
						for (int i = nd - 1; i >= 0; i--) begin
							text.push_back(CH_ZERO + {4'd0, digs[i]});
						end
					end
					CH_X: begin
						for (int i = 0; i < HEX_COUNT; i++) begin
							wide = {32'd0, it.arg_word} >> ((HEX_COUNT - 1 - i) * 4);
							nib = wide[3:0];
							text.push_back(GLYPHS[8 * (15 - nib) +: 8]);
						end
					end
					default: begin
					end
				endcase
			end
			for (int i = 0; i < text.size(); i++) begin
				c.out_char = text[i];
				c.last = (i == text.size() - 1);
				expected_chars.push_back(c);
			end
		endfunction

		function void check_char(chr_item_t got);
			chr_item_t want;
			checked++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected char, expected none, actual %h last %b",
					$time, got.out_char, got.last);
				return;
			end
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char) begin
				mismatches++;
				$display("%0t: out_char expected %h actual %h", $time, want.out_char,
					got.out_char);
			end
			if (got.last !== want.last) begin
				mismatches++;
				$display("%0t: last expected %b actual %b (char %h)", $time, want.last,
					got.last, want.out_char);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      fmt_valid;
	logic      fmt_stall;
	fmt_item_t fmt_item;
	logic      chr_valid;
	logic      chr_stall;
	chr_item_t chr_item;

	emitted_text_board sb = new;
	int burst_left = 0;
	bit draining = 1'b0;

	format_conversion_char_emitter_core #(
		.HEX_DIGITS(HEX_COUNT),
		.MAX_DEC_DIGITS(DEC_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.fmt_valid(fmt_valid),
		.fmt_stall(fmt_stall),
		.fmt_item(fmt_item),
		.chr_valid(chr_valid),
		.chr_stall(chr_stall),
		.chr_item(chr_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] pick_arg();
		logic [31:0] a;
		case ($urandom_range(0, 5))
			0: a = $urandom_range(0, 99);
			1: a = 32'h8000_0000 + $urandom_range(0, 3);
			2: a = 32'hFFFF_FFFF - $urandom_range(0, 20);
			3: a = 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: a = $urandom;
		endcase
		return a;
	endfunction

	// called and returns at a falling edge; bursts of items, mostly with idle gaps between
	task automatic send_format(input logic [7:0] ch, input logic [31:0] arg);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				fmt_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		fmt_valid <= 1'b1;
		fmt_item <= '{fmt_char: ch, arg_word: arg};
		@(posedge clk);
		while (fmt_stall) @(posedge clk);
		sb.note_format('{fmt_char: ch, arg_word: arg});
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_conversion(input logic [7:0] conv, input logic [31:0] arg);
		send_format(CH_PERCENT, $urandom);
		send_format(conv, arg);
	endtask

	// receiver: checks at the rising edge, changes its stall at the falling edge
	initial begin
		int mode;
		int mode_left;
		int hold;
		int tick;
		bit held_off;
		chr_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		hold = 0;
		tick = 0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && chr_valid && !chr_stall) begin
				sb.check_char(chr_item);
			end
			@(negedge clk);
			tick++;
			if (hold > 0) begin
				hold--;
				chr_stall <= 1'b1;
			end else if (!held_off && sb.checked >= 20) begin
				// long hold-off so the block backs up into its input
				held_off = 1'b1;
				hold = $urandom_range(60, 100);
				chr_stall <= 1'b1;
			end else if (draining) begin
				chr_stall <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 60);
				end
				mode_left--;
				case (mode)
					0: chr_stall <= 1'b0;
					1: chr_stall <= ($urandom_range(0, 2) == 0);
					default: chr_stall <= tick[1];
				endcase
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int count;
		int sel;
		logic [7:0] conv;
		arst_n = 1'b0;
		fmt_valid = 1'b0;
		fmt_item = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: plain bytes, each conversion, the numeric extremes
		send_format(CH_A, 32'h0);
		send_format(CH_NUL, 32'hFFFF_FFFF);
		send_format(CH_ALL1, 32'h0);
		send_conversion(CH_C, 32'h1234_5641);
		send_conversion(CH_D, 32'h0);
		send_conversion(CH_D, 32'h8000_0000);
		send_conversion(CH_D, 32'h7FFF_FFFF);
		send_conversion(CH_D, 32'hFFFF_FFFF);
		send_conversion(CH_X, 32'hDEAD_BEEF);
		send_conversion(CH_X, 32'h0);
		send_conversion(CH_X, 32'hFFFF_FFFF);
		// percent after percent, zero byte as conversion, unknown conversion
		send_conversion(CH_PERCENT, 32'h0);
		send_conversion(CH_NUL, 32'hFFFF_FFFF);
		send_conversion(CH_Q, 32'h5555_AAAA);

		count = 0;
		while (count < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				case ($urandom_range(0, 9))
					0, 1, 2: conv = CH_C;
					3, 4, 5: conv = CH_D;
					6, 7: conv = CH_X;
					8: conv = CH_PERCENT;
					default: conv = 8'($urandom_range(0, 255));
				endcase
				send_conversion(conv, pick_arg());
				count += 2;
			end else begin
				send_format(8'($urandom_range(0, 255)), $urandom);
				count++;
			end
		end
		fmt_valid <= 1'b0;
		draining = 1'b1;

		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
